FILE: sv/gcfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcfd_pkg
// Types, codes and the decode sequence table of the GPS / compass frame
// decoder.
// ----------------------------------------------------------------------------
package gcfd_pkg;

  // Frame bytes
  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] ID_GPS      = 8'h10;
  localparam logic [7:0] ID_COMPASS  = 8'h20;
  localparam logic [7:0] LEN_GPS     = 8'h3A;
  localparam logic [7:0] LEN_COMPASS = 8'h06;

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  // Configuration registers
  localparam int CFG_COUNT = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_HI = 3'd5;
  localparam logic [CFG_W-1:0] CFG_RESET [CFG_COUNT] = '{
    16'hFE55, 16'h0266, 16'hFE0A, 16'h022C, 16'hFE4B, 16'h021E
  };

  typedef enum logic [4:0] {
    FLD_SEC    = 5'd0,
    FLD_MIN    = 5'd1,
    FLD_HOUR   = 5'd2,
    FLD_DAY    = 5'd3,
    FLD_MONTH  = 5'd4,
    FLD_YEAR   = 5'd5,
    FLD_LON    = 5'd6,
    FLD_LAT    = 5'd7,
    FLD_ALT    = 5'd8,
    FLD_VEL_N  = 5'd9,
    FLD_VEL_E  = 5'd10,
    FLD_VEL_UP = 5'd11,
    FLD_VDOP   = 5'd12,
    FLD_NDOP   = 5'd13,
    FLD_EDOP   = 5'd14,
    FLD_SATS   = 5'd15,
    FLD_FIX    = 5'd16,
    FLD_RAW_X  = 5'd17,
    FLD_RAW_Y  = 5'd18,
    FLD_RAW_Z  = 5'd19,
    FLD_CEN_X  = 5'd20,
    FLD_CEN_Y  = 5'd21,
    FLD_CEN_Z  = 5'd22
  } field_t;

  // What the decode stage does with the byte read for a step.
  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_MASK_GPS = 3'd1,
    ACT_MASK_CMP = 3'd2,
    ACT_UNMASK   = 3'd3,
    ACT_RAW      = 3'd4
  } act_t;

  typedef struct packed {
    logic [5:0] addr;
    act_t       act;
    logic       emit;
    field_t     code;
    logic       last;
  } uop_t;

  localparam int         UOP_COUNT = 52;
  localparam logic [5:0] GPS_START = 6'd0;
  localparam logic [5:0] CMP_START = 6'd43;

  localparam logic [2:0] FIX_NONE = 3'd0;
  localparam logic [2:0] FIX_2D   = 3'd1;
  localparam logic [2:0] FIX_3D   = 3'd2;
  localparam logic [2:0] FIX_DIFF = 3'd3;

  function automatic uop_t mk(input logic [5:0] addr, input act_t act,
                              input logic emit, input field_t code,
                              input logic last);
    uop_t u;
    u.addr = addr;
    u.act  = act;
    u.emit = emit;
    u.code = code;
    u.last = last;
    return u;
  endfunction

  // Decode sequence: each step reads one payload byte and may emit a result.
  function automatic uop_t uop_rom(input logic [5:0] pc);
    uop_t u;
    u = mk(6'd0, ACT_NONE, 1'b0, FLD_SEC, 1'b1);
    case (pc)
      6'd0:  u = mk(6'd55, ACT_MASK_GPS, 1'b0, FLD_SEC, 1'b0);
      6'd1:  u = mk(6'd0,  ACT_UNMASK, 1'b0, FLD_SEC, 1'b0);
      6'd2:  u = mk(6'd1,  ACT_UNMASK, 1'b0, FLD_SEC, 1'b0);
      6'd3:  u = mk(6'd2,  ACT_UNMASK, 1'b0, FLD_SEC, 1'b0);
      6'd4:  u = mk(6'd3,  ACT_UNMASK, 1'b1, FLD_SEC, 1'b0);
      6'd5:  u = mk(6'd0,  ACT_NONE,   1'b1, FLD_MIN, 1'b0);
      6'd6:  u = mk(6'd0,  ACT_NONE,   1'b1, FLD_HOUR, 1'b0);
      6'd7:  u = mk(6'd0,  ACT_NONE,   1'b1, FLD_DAY, 1'b0);
      6'd8:  u = mk(6'd0,  ACT_NONE,   1'b1, FLD_MONTH, 1'b0);
      6'd9:  u = mk(6'd0,  ACT_NONE,   1'b1, FLD_YEAR, 1'b0);
      6'd10: u = mk(6'd4,  ACT_UNMASK, 1'b0, FLD_LON, 1'b0);
      6'd11: u = mk(6'd5,  ACT_UNMASK, 1'b0, FLD_LON, 1'b0);
      6'd12: u = mk(6'd6,  ACT_UNMASK, 1'b0, FLD_LON, 1'b0);
      6'd13: u = mk(6'd7,  ACT_UNMASK, 1'b1, FLD_LON, 1'b0);
      6'd14: u = mk(6'd8,  ACT_UNMASK, 1'b0, FLD_LAT, 1'b0);
      6'd15: u = mk(6'd9,  ACT_UNMASK, 1'b0, FLD_LAT, 1'b0);
      6'd16: u = mk(6'd10, ACT_UNMASK, 1'b0, FLD_LAT, 1'b0);
      6'd17: u = mk(6'd11, ACT_UNMASK, 1'b1, FLD_LAT, 1'b0);
      6'd18: u = mk(6'd12, ACT_UNMASK, 1'b0, FLD_ALT, 1'b0);
      6'd19: u = mk(6'd13, ACT_UNMASK, 1'b0, FLD_ALT, 1'b0);
      6'd20: u = mk(6'd14, ACT_UNMASK, 1'b0, FLD_ALT, 1'b0);
      6'd21: u = mk(6'd15, ACT_UNMASK, 1'b1, FLD_ALT, 1'b0);
      6'd22: u = mk(6'd28, ACT_UNMASK, 1'b0, FLD_VEL_N, 1'b0);
      6'd23: u = mk(6'd29, ACT_UNMASK, 1'b0, FLD_VEL_N, 1'b0);
      6'd24: u = mk(6'd30, ACT_UNMASK, 1'b0, FLD_VEL_N, 1'b0);
      6'd25: u = mk(6'd31, ACT_UNMASK, 1'b1, FLD_VEL_N, 1'b0);
      6'd26: u = mk(6'd32, ACT_UNMASK, 1'b0, FLD_VEL_E, 1'b0);
      6'd27: u = mk(6'd33, ACT_UNMASK, 1'b0, FLD_VEL_E, 1'b0);
      6'd28: u = mk(6'd34, ACT_UNMASK, 1'b0, FLD_VEL_E, 1'b0);
      6'd29: u = mk(6'd35, ACT_UNMASK, 1'b1, FLD_VEL_E, 1'b0);
      6'd30: u = mk(6'd36, ACT_UNMASK, 1'b0, FLD_VEL_UP, 1'b0);
      6'd31: u = mk(6'd37, ACT_UNMASK, 1'b0, FLD_VEL_UP, 1'b0);
      6'd32: u = mk(6'd38, ACT_UNMASK, 1'b0, FLD_VEL_UP, 1'b0);
      6'd33: u = mk(6'd39, ACT_UNMASK, 1'b1, FLD_VEL_UP, 1'b0);
      6'd34: u = mk(6'd42, ACT_UNMASK, 1'b0, FLD_VDOP, 1'b0);
      6'd35: u = mk(6'd43, ACT_UNMASK, 1'b1, FLD_VDOP, 1'b0);
      6'd36: u = mk(6'd44, ACT_UNMASK, 1'b0, FLD_NDOP, 1'b0);
      6'd37: u = mk(6'd45, ACT_UNMASK, 1'b1, FLD_NDOP, 1'b0);
      6'd38: u = mk(6'd46, ACT_UNMASK, 1'b0, FLD_EDOP, 1'b0);
      6'd39: u = mk(6'd47, ACT_UNMASK, 1'b1, FLD_EDOP, 1'b0);
      6'd40: u = mk(6'd48, ACT_RAW,    1'b1, FLD_SATS, 1'b0);
      6'd41: u = mk(6'd50, ACT_UNMASK, 1'b0, FLD_FIX, 1'b0);
      6'd42: u = mk(6'd52, ACT_UNMASK, 1'b1, FLD_FIX, 1'b1);
      6'd43: u = mk(6'd4,  ACT_MASK_CMP, 1'b0, FLD_RAW_X, 1'b0);
      6'd44: u = mk(6'd0,  ACT_UNMASK, 1'b0, FLD_RAW_X, 1'b0);
      6'd45: u = mk(6'd1,  ACT_UNMASK, 1'b1, FLD_RAW_X, 1'b0);
      6'd46: u = mk(6'd2,  ACT_UNMASK, 1'b0, FLD_RAW_Y, 1'b0);
      6'd47: u = mk(6'd3,  ACT_UNMASK, 1'b1, FLD_RAW_Y, 1'b0);
      6'd48: u = mk(6'd5,  ACT_UNMASK, 1'b1, FLD_RAW_Z, 1'b0);
      6'd49: u = mk(6'd0,  ACT_NONE,   1'b1, FLD_CEN_X, 1'b0);
      6'd50: u = mk(6'd0,  ACT_NONE,   1'b1, FLD_CEN_Y, 1'b0);
      6'd51: u = mk(6'd0,  ACT_NONE,   1'b1, FLD_CEN_Z, 1'b1);
      default: u = mk(6'd0, ACT_NONE, 1'b0, FLD_SEC, 1'b1);
    endcase
    return u;
  endfunction

  // Compass mask, derived from the raw low byte of the z axis.
  function automatic logic [7:0] cmp_mask(input logic [7:0] r);
    logic [7:0] base;
    logic [7:0] flip;
    base = {r[4:1], r[3:0] ^ r[7:4]};
    flip = {r[0], 3'b000, r[0], 3'b000};
    return base ^ flip;
  endfunction

endpackage

FILE: sv/gps_compass_frame_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_compass_frame_decoder_unit
// Frames GPS and compass messages from a byte stream, checks the running
// sums and decodes a good message into a run of (field, value) items.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)               | tlast
//  in_     | slave     | rx_byte[7:0]                     | -
//  out_    | master    | field_code[4:0], field_value[31:0] | last_of_frame
//  cfg_    | write     | index 0..5, 16-bit limit         | -
//
// One received byte is taken every cycle but for the hold-off below. A good
// frame is decoded by a step sequencer reading one payload byte per cycle
// if not stalled: GPS takes 43 steps for 17 items, compass 9 steps for 6.
// The payload memory holds two banks, so the next frame fills one bank while
// the last is decoded; the input holds off only on the final check byte of a
// frame while the previous frame is still being decoded.
// Reset is synchronous; the payload memory is not cleared.
// A stalled output holds the sequencer, with the memory re-reading its step.
// ----------------------------------------------------------------------------
module gps_compass_frame_decoder_unit #(
  parameter int PAYLOAD_BYTES = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // rx_byte[7:0]
  input  logic [gcfd_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // field_code[4:0], field_value[36:5], zero fill [39:37]
  output logic [gcfd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic                                  out_tlast,
  input  logic                                  cfg_we,
  input  logic [gcfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gcfd_pkg::CFG_W-1:0]            cfg_wdata
);
  import gcfd_pkg::*;

  localparam int AW = $clog2(PAYLOAD_BYTES);
  localparam int MEM_DEPTH = 2 ** (AW + 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_SYNC, PH_ID, PH_LEN, PH_PAY, PH_CK1, PH_CK2
  } phase_t;

  // Framer
  phase_t       phase_r;
  logic [5:0]   byte_count_r;
  logic [7:0]   kind_r;
  logic [5:0]   length_r;
  logic [7:0]   sum_first_r;
  logic [7:0]   sum_second_r;
  logic         bank_w_r;

  logic [7:0]   rx_byte;
  logic         in_fire;
  logic [7:0]   sum_first_nxt;
  logic [7:0]   sum_second_nxt;
  logic [5:0]   count_inc;
  logic         len_ok;
  logic         pay_wr;
  logic         frame_done;

  logic [CFG_W-1:0] cfg_r [CFG_COUNT];

  // Payload memory, two banks
  logic [7:0]   mem [MEM_DEPTH];
  logic [7:0]   rd_q_r;
  logic [5:0]   rd_addr;

  // Sequencer
  logic         active_r;
  logic [5:0]   pc_r;
  logic         dec_bank_r;
  uop_t         uop_cur;
  logic         s2_valid_r;
  uop_t         s2_uop_r;
  logic         stall;
  logic         s1_fire;
  logic         s2_exec;
  logic         dec_busy;

  logic [7:0]   mask_r;
  logic [7:0]   raw_r;
  logic [31:0]  asm_r;
  logic [15:0]  ax_r [3];

  logic [31:0]  asm_nxt;
  logic [31:0]  value;
  logic [1:0]   ax_idx;
  logic [15:0]  ax_val;

  logic         out_valid_r;
  logic [4:0]   out_code_r;
  logic [31:0]  out_value_r;
  logic         out_last_r;

  assign rx_byte = in_tdata[7:0];
  assign dec_busy = active_r || s2_valid_r;
  assign in_tready = !(phase_r == PH_CK2 && dec_busy);
  assign in_fire = in_tvalid && in_tready;

  assign sum_first_nxt  = sum_first_r + rx_byte;
  assign sum_second_nxt = sum_second_r + sum_first_nxt;
  assign count_inc      = byte_count_r + 6'd1;
  assign len_ok = (kind_r == ID_GPS && rx_byte == LEN_GPS) ||
                  (kind_r == ID_COMPASS && rx_byte == LEN_COMPASS);
  assign pay_wr     = in_fire && phase_r == PH_PAY;
  assign frame_done = in_fire && phase_r == PH_CK2 && rx_byte == sum_second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      byte_count_r <= '0;
      kind_r       <= '0;
      length_r     <= '0;
      sum_first_r  <= '0;
      sum_second_r <= '0;
      bank_w_r     <= 1'b0;
    end else if (in_fire) begin
      unique case (phase_r)
        PH_IDLE: phase_r <= (rx_byte == SYNC_FIRST) ? PH_SYNC : PH_IDLE;
        PH_SYNC: begin
          if (rx_byte == SYNC_SECOND) begin
            sum_first_r  <= '0;
            sum_second_r <= '0;
            phase_r      <= PH_ID;
          end else begin
            phase_r <= PH_IDLE;
          end
        end
        PH_ID: begin
          kind_r       <= rx_byte;
          sum_first_r  <= sum_first_nxt;
          sum_second_r <= sum_second_nxt;
          phase_r      <= PH_LEN;
        end
        PH_LEN: begin
          if (len_ok) begin
            length_r     <= rx_byte[5:0];
            byte_count_r <= '0;
            sum_first_r  <= sum_first_nxt;
            sum_second_r <= sum_second_nxt;
            phase_r      <= PH_PAY;
          end else begin
            phase_r <= PH_IDLE;
          end
        end
        PH_PAY: begin
          byte_count_r <= count_inc;
          sum_first_r  <= sum_first_nxt;
          sum_second_r <= sum_second_nxt;
          if (count_inc >= length_r) phase_r <= PH_CK1;
        end
        PH_CK1: phase_r <= (rx_byte == sum_first_r) ? PH_CK2 : PH_IDLE;
        PH_CK2: begin
          phase_r <= PH_IDLE;
          // A good frame hands its bank to the sequencer.
          if (frame_done) bank_w_r <= !bank_w_r;
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_COUNT; i++) cfg_r[i] <= CFG_RESET[i];
    end else if (cfg_we && cfg_index < CFG_IDX_W'(CFG_COUNT)) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  // While stalled the memory re-reads the held step, so its data survives.
  assign uop_cur = uop_rom(pc_r);
  assign stall   = s2_valid_r && s2_uop_r.emit && out_valid_r && !out_tready;
  assign s1_fire = active_r && !stall;
  assign s2_exec = s2_valid_r && !stall;
  assign rd_addr = stall ? s2_uop_r.addr : uop_cur.addr;

  always_ff @(posedge clk) begin
    if (pay_wr) mem[{bank_w_r, AW'(byte_count_r)}] <= rx_byte;
    rd_q_r <= mem[{dec_bank_r, AW'(rd_addr)}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      pc_r       <= '0;
      dec_bank_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (frame_done) begin
        active_r   <= 1'b1;
        pc_r       <= (kind_r == ID_GPS) ? GPS_START : CMP_START;
        dec_bank_r <= bank_w_r;
      end else if (s1_fire) begin
        pc_r <= pc_r + 6'd1;
        if (uop_cur.last) active_r <= 1'b0;
      end
      if (!stall) s2_valid_r <= s1_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) s2_uop_r <= uop_cur;
  end

  always_comb begin
    case (s2_uop_r.act)
      ACT_UNMASK: asm_nxt = {rd_q_r ^ mask_r, asm_r[31:8]};
      ACT_RAW:    asm_nxt = {rd_q_r, asm_r[31:8]};
      default:    asm_nxt = asm_r;
    endcase
  end

  always_comb begin
    logic [5:0]  day;
    logic [7:0]  ftype;
    logic [7:0]  fflag;
    logic [2:0]  fix;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] cl;
    logic [17:0] cen;
    day   = {1'b0, asm_nxt[20:16]} + {5'd0, (asm_nxt[15:12] > 4'd7)};
    ftype = asm_nxt[23:16];
    fflag = asm_nxt[31:24];
    fix   = (ftype == 8'd2) ? FIX_2D : (ftype == 8'd3) ? FIX_3D : FIX_NONE;
    if (fix != FIX_NONE && fflag[1]) fix = FIX_DIFF;

    case (s2_uop_r.code) inside
      FLD_RAW_Y, FLD_CEN_Y: ax_idx = 2'd1;
      FLD_RAW_Z, FLD_CEN_Z: ax_idx = 2'd2;
      default:              ax_idx = 2'd0;
    endcase
    ax_val = (s2_uop_r.code == FLD_RAW_Z) ? {asm_nxt[31:24], raw_r} : asm_nxt[31:16];

    // Upper clamp first, so inverted limits give the lower one.
    lo  = cfg_r[{ax_idx, 1'b0}];
    hi  = cfg_r[{ax_idx, 1'b1}];
    cl  = ($signed(ax_r[ax_idx]) > $signed(hi)) ? hi : ax_r[ax_idx];
    cl  = ($signed(cl) < $signed(lo)) ? lo : cl;
    cen = {cl[15], cl, 1'b0} - ({{2{lo[15]}}, lo} + {{2{hi[15]}}, hi});

    case (s2_uop_r.code) inside
      FLD_SEC:   value = {26'd0, asm_nxt[5:0]};
      FLD_MIN:   value = {26'd0, asm_nxt[11:6]};
      FLD_HOUR:  value = {28'd0, asm_nxt[15:12]};
      FLD_DAY:   value = {26'd0, day};
      FLD_MONTH: value = {28'd0, asm_nxt[24:21]};
      FLD_YEAR:  value = {25'd0, asm_nxt[31:25]};
      FLD_LON, FLD_LAT, FLD_ALT, FLD_VEL_N, FLD_VEL_E: value = asm_nxt;
      FLD_VEL_UP: value = 32'd0 - asm_nxt;
      FLD_VDOP, FLD_NDOP, FLD_EDOP: value = {{16{asm_nxt[31]}}, asm_nxt[31:16]};
      FLD_SATS:  value = {24'd0, asm_nxt[31:24]};
      FLD_FIX:   value = {29'd0, fix};
      FLD_RAW_X, FLD_RAW_Y, FLD_RAW_Z: value = {{16{ax_val[15]}}, ax_val};
      FLD_CEN_X, FLD_CEN_Y, FLD_CEN_Z: value = {{14{cen[17]}}, cen};
      default:   value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s2_exec) begin
      asm_r <= asm_nxt;
      if (s2_uop_r.act == ACT_MASK_GPS) mask_r <= rd_q_r;
      if (s2_uop_r.act == ACT_MASK_CMP) begin
        mask_r <= cmp_mask(rd_q_r);
        raw_r  <= rd_q_r;
      end
      if (s2_uop_r.emit && (s2_uop_r.code == FLD_RAW_X || s2_uop_r.code == FLD_RAW_Y ||
                            s2_uop_r.code == FLD_RAW_Z)) begin
        ax_r[ax_idx] <= ax_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_exec && s2_uop_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_exec && s2_uop_r.emit) begin
      out_code_r  <= s2_uop_r.code;
      out_value_r <= value;
      out_last_r  <= s2_uop_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_value_r, out_code_r};
  assign out_tlast  = out_last_r;

  // A new frame never starts decoding on top of one still in flight.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |-> !dec_busy)
    else $error("frame handed over while decoder busy");

  // The final step leaves the sequencer stopped.
  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_uop_r.last) |-> !active_r)
    else $error("sequencer still running after final step");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (pc_r < 6'(UOP_COUNT)))
    else $error("sequencer step beyond table");

  a_last_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |->
      (out_code_r == FLD_FIX || out_code_r == FLD_CEN_Z))
    else $error("end of frame on a field that does not close a message");

endmodule

FILE: verif/gcfd_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcfd_scoreboard_pkg
// Scoreboard for the GPS / compass frame decoder. It follows the byte framer
// on every accepted input item, decodes each good frame itself and holds the
// field items that the block must produce, in order.
// ----------------------------------------------------------------------------
package gcfd_scoreboard_pkg;
  import gcfd_pkg::*;

  typedef enum logic [2:0] {
    RX_IDLE,
    RX_SYNC,
    RX_ID,
    RX_LEN,
    RX_BODY,
    RX_CHECK_A,
    RX_CHECK_B
  } rx_phase_t;

  typedef struct {
    field_t      code;
    logic [31:0] value;
    logic        last;
  } field_item_t;

  // Key that hides the compass payload, built from the raw low byte of z.
  function automatic logic [7:0] compass_key(input logic [7:0] r);
    logic [7:0] k;
    k[3:0] = r[3:0] ^ r[7:4];
    k[7:4] = r[4:1];
    k[3]   = k[3] ^ r[0];
    k[7]   = k[7] ^ r[0];
    return k;
  endfunction

  class field_scoreboard;
    field_item_t awaited[$];
    logic [15:0] limit_reg [CFG_COUNT];
    rx_phase_t   phase;
    logic [5:0]  body_count;
    logic [7:0]  msg_id;
    logic [7:0]  msg_len;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  body [64];
    int          mismatches;

    function new();
      limit_reg  = '{16'(-427), 16'(614), 16'(-502), 16'(556), 16'(-437), 16'(542)};
      phase      = RX_IDLE;
      body_count = '0;
      msg_id     = '0;
      msg_len    = '0;
      sum_a      = '0;
      sum_b      = '0;
      mismatches = 0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
      limit_reg[idx] = value;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    function void fold(logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
    endfunction

    function void add_field(field_t code, logic [31:0] value, logic last);
      field_item_t f;
      f.code  = code;
      f.value = value;
      f.last  = last;
      awaited.push_back(f);
    endfunction

    function logic [31:0] word_at(int at, logic [7:0] k);
      return {body[at+3] ^ k, body[at+2] ^ k, body[at+1] ^ k, body[at] ^ k};
    endfunction

    function logic [31:0] half_at(int at, logic [7:0] k);
      logic [15:0] h;
      h = {body[at+1] ^ k, body[at] ^ k};
      return {{16{h[15]}}, h};
    endfunction

    function logic [31:0] centre_axis(int v, logic [15:0] lo_raw, logic [15:0] hi_raw);
      int lo;
      int hi;
      lo = $signed(lo_raw);
      hi = $signed(hi_raw);
      // The upper bound is applied first, so inverted limits give the lower one.
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return 2 * v - (lo + hi);
    endfunction

    function void decode_gps();
      logic [7:0]  k;
      logic [31:0] t;
      logic [5:0]  day;
      logic [7:0]  ftype;
      logic [7:0]  fflag;
      logic [2:0]  fix;
      k   = body[55];
      t   = word_at(0, k);
      // Past hour seven the day is reported one on, so it can reach 32.
      day = {1'b0, t[20:16]} + ((t[15:12] > 4'd7) ? 6'd1 : 6'd0);
      add_field(FLD_SEC,    32'(t[5:0]),   1'b0);
      add_field(FLD_MIN,    32'(t[11:6]),  1'b0);
      add_field(FLD_HOUR,   32'(t[15:12]), 1'b0);
      add_field(FLD_DAY,    32'(day),      1'b0);
      add_field(FLD_MONTH,  32'(t[24:21]), 1'b0);
      add_field(FLD_YEAR,   32'(t[31:25]), 1'b0);
      add_field(FLD_LON,    word_at(4, k),  1'b0);
      add_field(FLD_LAT,    word_at(8, k),  1'b0);
      add_field(FLD_ALT,    word_at(12, k), 1'b0);
      add_field(FLD_VEL_N,  word_at(28, k), 1'b0);
      add_field(FLD_VEL_E,  word_at(32, k), 1'b0);
      add_field(FLD_VEL_UP, 32'd0 - word_at(36, k), 1'b0);
      add_field(FLD_VDOP,   half_at(42, k), 1'b0);
      add_field(FLD_NDOP,   half_at(44, k), 1'b0);
      add_field(FLD_EDOP,   half_at(46, k), 1'b0);
      add_field(FLD_SATS,   32'(body[48]),  1'b0);
      ftype = body[50] ^ k;
      fflag = body[52] ^ k;
      fix   = (ftype == 8'd2) ? FIX_2D : (ftype == 8'd3) ? FIX_3D : FIX_NONE;
      if (fix != FIX_NONE && fflag[1]) fix = FIX_DIFF;
      add_field(FLD_FIX, 32'(fix), 1'b1);
    endfunction

    function void decode_compass();
      logic [7:0] k;
      int         ax [3];
      k     = compass_key(body[4]);
      ax[0] = $signed({body[1] ^ k, body[0] ^ k});
      ax[1] = $signed({body[3] ^ k, body[2] ^ k});
      // The low byte of z is carried in the clear.
      ax[2] = $signed({body[5] ^ k, body[4]});
      add_field(FLD_RAW_X, ax[0], 1'b0);
      add_field(FLD_RAW_Y, ax[1], 1'b0);
      add_field(FLD_RAW_Z, ax[2], 1'b0);
      add_field(FLD_CEN_X, centre_axis(ax[0], limit_reg[CFG_X_LO], limit_reg[CFG_X_HI]), 1'b0);
      add_field(FLD_CEN_Y, centre_axis(ax[1], limit_reg[CFG_Y_LO], limit_reg[CFG_Y_HI]), 1'b0);
      add_field(FLD_CEN_Z, centre_axis(ax[2], limit_reg[CFG_Z_LO], limit_reg[CFG_Z_HI]), 1'b1);
    endfunction

    // Any byte that does not fit the phase drops back to idle and is not
    // looked at again as the start of a new frame.
    function void take_rx_byte(logic [7:0] b);
      case (phase)
        RX_IDLE: begin
          if (b == SYNC_FIRST) phase = RX_SYNC;
        end
        RX_SYNC: begin
          if (b == SYNC_SECOND) begin
            sum_a = '0;
            sum_b = '0;
            phase = RX_ID;
          end else begin
            phase = RX_IDLE;
          end
        end
        RX_ID: begin
          msg_id = b;
          fold(b);
          phase = RX_LEN;
        end
        RX_LEN: begin
          if ((msg_id == ID_GPS && b == LEN_GPS) || (msg_id == ID_COMPASS && b == LEN_COMPASS)) begin
            msg_len    = b;
            body_count = '0;
            fold(b);
            phase = RX_BODY;
          end else begin
            phase = RX_IDLE;
          end
        end
        RX_BODY: begin
          body[body_count] = b;
          body_count = body_count + 6'd1;
          fold(b);
          if (body_count >= msg_len) phase = RX_CHECK_A;
        end
        RX_CHECK_A: begin
          phase = (b == sum_a) ? RX_CHECK_B : RX_IDLE;
        end
        RX_CHECK_B: begin
          phase = RX_IDLE;
          if (b == sum_b) begin
            if (msg_id == ID_GPS) decode_gps();
            else decode_compass();
          end
        end
        default: begin
          phase = RX_IDLE;
        end
      endcase
    endfunction

    task check_result(logic [4:0] code, logic [31:0] value, logic last);
      field_item_t e;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected item code %0d value %0d last %0b",
                         code, $signed(value), last));
        return;
      end
      e = awaited.pop_front();
      if (code !== e.code)
        report($sformatf("field code %0d, wanted %0d", code, e.code));
      if (value !== e.value)
        report($sformatf("field %0d value %0d, wanted %0d", e.code, $signed(value),
                         $signed(e.value)));
      if (last !== e.last)
        report($sformatf("field %0d last %0b, wanted %0b", e.code, last, e.last));
    endtask
  endclass

endpackage

FILE: verif/gps_compass_frame_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_compass_frame_decoder_unit testbench
// Feeds directed and random byte streams of GPS and compass frames, good,
// damaged and mixed with noise, under several limit settings and with random
// stalls on both streams. Every field item out of the block is checked
// against the scoreboard's own decode of the same stream.
// ----------------------------------------------------------------------------
module tb;
  import gcfd_pkg::*;
  import gcfd_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_BYTES   = 16;
  localparam logic [7:0] ID_UNKNOWN = 8'h30;
  localparam logic [CFG_IDX_W-1:0] LIMIT_REG [CFG_COUNT] = '{
    CFG_X_LO, CFG_X_HI, CFG_Y_LO, CFG_Y_HI, CFG_Z_LO, CFG_Z_HI
  };

  typedef enum int {
    DMG_NONE    = 0,
    DMG_CHECK_A = 1,
    DMG_CHECK_B = 2,
    DMG_SYNC    = 3,
    DMG_CUT     = 4
  } damage_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   out_tlast;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  field_scoreboard board = new();

  int          tx_idle_pct  = 0;
  int          rx_idle_pct  = 0;
  int          hold_request = 0;
  int          hold_taken   = 0;
  int          hold_left    = 0;
  int          cycle_count  = 0;
  int          bytes_sent   = 0;
  logic [7:0]  frame_body [64];
  int          body_len     = 0;
  logic [15:0] limit_val [CFG_COUNT];

  gps_compass_frame_decoder_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Result side: random back-pressure, or a long hold-off when asked for.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_request != hold_taken) begin
      hold_taken <= hold_request;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata[4:0], out_tdata[36:5], out_tlast);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** gps_compass_frame_decoder_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= b;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    board.take_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input damage_t damage);
    logic [7:0] run_a;
    logic [7:0] run_b;
    int         i;
    int         stop;
    run_a = id;
    run_b = id;
    run_a = run_a + len;
    run_b = run_b + run_a;
    for (i = 0; i < body_len; i++) begin
      run_a = run_a + frame_body[i];
      run_b = run_b + run_a;
    end
    send_byte(SYNC_FIRST);
    send_byte((damage == DMG_SYNC) ? SYNC_FIRST : SYNC_SECOND);
    send_byte(id);
    send_byte(len);
    stop = (damage == DMG_CUT) ? $urandom_range(body_len - 1) : body_len;
    for (i = 0; i < stop; i++) send_byte(frame_body[i]);
    if (damage != DMG_CUT) begin
      send_byte((damage == DMG_CHECK_A) ? run_a ^ 8'($urandom_range(255, 1)) : run_a);
      send_byte((damage == DMG_CHECK_B) ? run_b ^ 8'($urandom_range(255, 1)) : run_b);
    end
  endtask

  // Payload byte 55 is the key; the satellite count stays in the clear.
  task automatic fill_gps(input logic [7:0] key, input logic [31:0] stamp,
                          input logic [31:0] climb, input logic [7:0] ftype,
                          input logic [7:0] fflag);
    int j;
    body_len = LEN_GPS;
    for (j = 0; j < body_len; j++) frame_body[j] = 8'($urandom);
    frame_body[55] = key;
    for (j = 0; j < 4; j++) begin
      frame_body[j]      = stamp[8*j +: 8] ^ key;
      frame_body[36 + j] = climb[8*j +: 8] ^ key;
    end
    frame_body[50] = ftype ^ key;
    frame_body[52] = fflag ^ key;
  endtask

  task automatic fill_compass(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
    logic [7:0] k;
    body_len = LEN_COMPASS;
    k = compass_key(z[7:0]);
    frame_body[0] = x[7:0] ^ k;
    frame_body[1] = x[15:8] ^ k;
    frame_body[2] = y[7:0] ^ k;
    frame_body[3] = y[15:8] ^ k;
    frame_body[4] = z[7:0];
    frame_body[5] = z[15:8] ^ k;
  endtask

  task automatic random_compass();
    logic [15:0] ax [3];
    int          i;
    // Half the axes sit near the limits so that unclamped values turn up too.
    for (i = 0; i < 3; i++)
      ax[i] = $urandom_range(1) ? 16'(int'($urandom_range(2400)) - 1200) : 16'($urandom);
    fill_compass(ax[0], ax[1], ax[2]);
  endtask

  task automatic random_gps();
    fill_gps(8'($urandom), $urandom, $urandom,
             $urandom_range(1) ? 8'($urandom_range(4)) : 8'($urandom), 8'($urandom));
  endtask

  task automatic random_traffic(input int n_bytes);
    int start;
    int pick;
    int d;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        random_compass();
        send_frame(ID_COMPASS, LEN_COMPASS, DMG_NONE);
      end else if (pick < 70) begin
        random_gps();
        send_frame(ID_GPS, LEN_GPS, DMG_NONE);
      end else if (pick < 85) begin
        d = $urandom_range(4);
        if ($urandom_range(1)) begin
          random_compass();
          if (d == 0) send_frame(ID_COMPASS, LEN_GPS, DMG_NONE);
          else send_frame(ID_COMPASS, LEN_COMPASS, damage_t'(d));
        end else begin
          random_gps();
          if (d == 0) send_frame(ID_GPS, LEN_COMPASS, DMG_NONE);
          else send_frame(ID_GPS, LEN_GPS, damage_t'(d));
        end
      end else begin
        repeat ($urandom_range(8, 1))
          send_byte(($urandom_range(4) == 0) ? SYNC_FIRST : 8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limits();
    int i;
    for (i = 0; i < CFG_COUNT; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= LIMIT_REG[i];
      cfg_wdata <= limit_val[i];
      @(posedge clk);
      board.set_limit(LIMIT_REG[i], limit_val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int i;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 11;
    rx_idle_pct = 81;

    // Stray bytes, then a frame behind a doubled first sync byte: the second
    // 0x55 breaks the sync and must not restart it, so that frame gives nothing.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_SECOND);
    fill_compass(16'd100, 16'(-1000), 16'd1000);
    send_byte(SYNC_FIRST);
    send_frame(ID_COMPASS, LEN_COMPASS, DMG_NONE);
    send_frame(ID_COMPASS, LEN_COMPASS, DMG_NONE);

    // Day rollover, most negative climb rate and the four fix classes.
    fill_gps(8'h00, {7'd127, 4'd12, 5'd31, 4'd15, 6'd59, 6'd59}, 32'h8000_0000, 8'd3, 8'h02);
    send_frame(ID_GPS, LEN_GPS, DMG_NONE);
    fill_gps(8'hFF, {7'd0, 4'd1, 5'd31, 4'd7, 6'd0, 6'd0}, 32'h0000_0001, 8'd2, 8'h00);
    send_frame(ID_GPS, LEN_GPS, DMG_NONE);
    fill_gps(8'h5A, $urandom, 32'h7FFF_FFFF, 8'd3, 8'hFD);
    send_frame(ID_GPS, LEN_GPS, DMG_NONE);
    fill_gps(8'hA5, $urandom, 32'hFFFF_FFFF, 8'd7, 8'hFF);
    send_frame(ID_GPS, LEN_GPS, DMG_NONE);

    // Lengths that do not match the id, an unknown id, bad check bytes and a cut frame.
    random_compass();
    send_frame(ID_GPS, LEN_COMPASS, DMG_NONE);
    send_frame(ID_COMPASS, LEN_GPS, DMG_NONE);
    send_frame(ID_UNKNOWN, LEN_COMPASS, DMG_NONE);
    send_frame(ID_COMPASS, LEN_COMPASS, DMG_CHECK_A);
    send_frame(ID_COMPASS, LEN_COMPASS, DMG_CHECK_B);
    send_frame(ID_COMPASS, LEN_COMPASS, DMG_CUT);
    send_frame(ID_COMPASS, LEN_COMPASS, DMG_NONE);

    // Widest limits, then inverted ones.
    wait_drained();
    for (i = 0; i < CFG_COUNT; i += 2) begin
      limit_val[i]     = 16'h8000;
      limit_val[i + 1] = 16'h7FFF;
    end
    write_limits();
    fill_compass(16'h7FFF, 16'h8000, 16'h0000);
    send_frame(ID_COMPASS, LEN_COMPASS, DMG_NONE);
    fill_compass(16'h8000, 16'h7FFF, 16'hFFFF);
    send_frame(ID_COMPASS, LEN_COMPASS, DMG_NONE);
    wait_drained();
    for (i = 0; i < CFG_COUNT; i += 2) begin
      limit_val[i]     = 16'd300;
      limit_val[i + 1] = 16'(-300);
    end
    write_limits();
    fill_compass(16'h0000, 16'h7FFF, 16'h8000);
    send_frame(ID_COMPASS, LEN_COMPASS, DMG_NONE);

    wait_drained();
    for (i = 0; i < CFG_COUNT; i += 2) begin
      limit_val[i]     = 16'(-int'($urandom_range(2000)));
      limit_val[i + 1] = 16'($urandom_range(2000));
    end
    write_limits();
    random_traffic(PHASE_BYTES);

    wait_drained();
    for (i = 0; i < CFG_COUNT; i++) limit_val[i] = 16'($urandom);
    write_limits();
    tx_idle_pct = 81;
    rx_idle_pct = 11;
    random_traffic(PHASE_BYTES / 2);
    wait_drained();
    random_traffic(PHASE_BYTES / 2);

    wait_drained();
    for (i = 0; i < CFG_COUNT; i += 2) begin
      limit_val[i]     = 16'h7FFF;
      limit_val[i + 1] = 16'h8000;
    end
    write_limits();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // Results are held back while frames keep coming, so the block fills up
    // and has to stall the input stream.
    hold_request++;
    repeat (3) begin
      random_compass();
      send_frame(ID_COMPASS, LEN_COMPASS, DMG_NONE);
    end
    random_traffic(PHASE_BYTES);

    wait_drained();
    if (board.mismatches == 0) begin
      $display("** gps_compass_frame_decoder_unit: PASSED **");
    end else begin
      $display("** gps_compass_frame_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
